@@ src/kaleidoscope_inverse_map_core_defines.svh @@
// Assertion macros shared by the kaleidoscope inverse map RTL.
// No dependencies; included by the top level.
`ifndef KALEIDOSCOPE_INVERSE_MAP_CORE_DEFINES_SVH
`define KALEIDOSCOPE_INVERSE_MAP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KIM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KIM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/kim_pkg.sv @@
// Shared types and constants of the kaleidoscope inverse map.
// No dependencies; imported by every module of the block.
package kim_pkg;

   localparam int QW    = 33;
   localparam int DW    = 52;
   localparam int ZW    = 34;
   localparam int GUARD = 16;

   localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

   localparam logic [2:0] REG_COEF_XX  = 3'd0;
   localparam logic [2:0] REG_COEF_XY  = 3'd1;
   localparam logic [2:0] REG_COEF_YX  = 3'd2;
   localparam logic [2:0] REG_COEF_YY  = 3'd3;
   localparam logic [2:0] REG_AFF_OFF  = 3'd4;
   localparam logic [2:0] REG_OUT_OFF  = 3'd5;
   localparam logic [2:0] REG_SECTORS  = 3'd6;

   localparam logic [31:0] ATAN_TURNS [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic valid;
      logic zero;
   } ctrl_type;

endpackage

@@ src/kim_affine.sv @@
// Affine stage pair: coefficient products, then rounding and translation.
// Depends on kim_pkg.
module kim_affine import kim_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [23:0]   pixel_x,
   input  logic signed [23:0]   pixel_y,
   input  logic signed [31:0]   coef_xx,
   input  logic signed [31:0]   coef_xy,
   input  logic signed [31:0]   coef_yx,
   input  logic signed [31:0]   coef_yy,
   input  logic [63:0]          affine_offset,
   output logic                 out_valid,
   output logic signed [QW-1:0] q_x,
   output logic signed [QW-1:0] q_y
);

   logic signed [55:0] p_xx_ff, p_xy_ff, p_yx_ff, p_yy_ff;
   logic               v1_ff, v2_ff;
   logic signed [56:0] sum_x, sum_y;
   logic signed [QW-1:0] q_x_in, q_y_in, q_x_ff, q_y_ff;

   always_ff @(posedge clock) begin
      p_xx_ff <= coef_xx * pixel_x;
      p_xy_ff <= coef_xy * pixel_y;
      p_yx_ff <= coef_yx * pixel_x;
      p_yy_ff <= coef_yy * pixel_y;
   end

   assign sum_x = 57'(p_xx_ff) + 57'(p_xy_ff) + 57'sd134217728;
   assign sum_y = 57'(p_yx_ff) + 57'(p_yy_ff) + 57'sd134217728;
   assign q_x_in = QW'($signed(sum_x[56:28])) + QW'($signed(affine_offset[31:0]));
   assign q_y_in = QW'($signed(sum_y[56:28])) + QW'($signed(affine_offset[63:32]));

   always_ff @(posedge clock) begin
      q_x_ff <= q_x_in;
      q_y_ff <= q_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign q_x = q_x_ff;
   assign q_y = q_y_ff;

endmodule

@@ src/kim_vector.sv @@
// Vectoring CORDIC pipeline: polar angle of the affine result, one step per stage.
// Depends on kim_pkg.
module kim_vector import kim_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [QW-1:0] q_x,
   input  logic signed [QW-1:0] q_y,
   output ctrl_type             out_ctrl,
   output logic [31:0]          angle,
   output logic signed [DW-1:0] r_x,
   output logic signed [DW-1:0] r_y
);

   localparam int N = CORDIC_STEPS;

   ctrl_type             st_ctrl [0:N];
   logic                 st_skip [0:N];
   logic signed [DW-1:0] st_vx   [0:N];
   logic signed [DW-1:0] st_vy   [0:N];
   logic [31:0]          st_a    [0:N];
   logic signed [DW-1:0] st_rx   [0:N];
   logic signed [DW-1:0] st_ry   [0:N];

   logic signed [DW-1:0] rx_in, ry_in, vx_in, vy_in;
   logic                 neg_in;
   ctrl_type             ctrl_in, ctrl0_ff;
   logic                 skip0_ff;
   logic signed [DW-1:0] vx0_ff, vy0_ff, rx0_ff, ry0_ff;
   logic [31:0]          a0_ff;

   assign rx_in  = DW'(q_x) <<< GUARD;
   assign ry_in  = DW'(q_y) <<< GUARD;
   assign neg_in = q_x[QW-1];
   assign vx_in  = neg_in ? -rx_in : rx_in;
   assign vy_in  = neg_in ? -ry_in : ry_in;
   assign ctrl_in.valid = in_valid;
   assign ctrl_in.zero  = (q_x == '0) && (q_y == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
      end else begin
         ctrl0_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      skip0_ff <= (vy_in == '0);
      vx0_ff   <= vx_in;
      vy0_ff   <= vy_in;
      a0_ff    <= neg_in ? HALF_TURN : 32'd0;
      rx0_ff   <= rx_in;
      ry0_ff   <= ry_in;
   end

   assign st_ctrl[0] = ctrl0_ff;
   assign st_skip[0] = skip0_ff;
   assign st_vx[0]   = vx0_ff;
   assign st_vy[0]   = vy0_ff;
   assign st_a[0]    = a0_ff;
   assign st_rx[0]   = rx0_ff;
   assign st_ry[0]   = ry0_ff;

   for (genvar i = 0; i < N; i++) begin : g_step
      ctrl_type             ctrl_ff;
      logic                 skip_ff;
      logic signed [DW-1:0] vx_ff, vy_ff, rx_ff, ry_ff;
      logic signed [DW-1:0] vx_in2, vy_in2, dx, dy;
      logic [31:0]          a_ff, a_in2;

      assign dx = st_vy[i] >>> i;
      assign dy = st_vx[i] >>> i;

      always_comb begin
         if (st_skip[i]) begin
            vx_in2 = st_vx[i];
            vy_in2 = st_vy[i];
            a_in2  = st_a[i];
         end else if (st_vy[i] > 0) begin
            vx_in2 = st_vx[i] + dx;
            vy_in2 = st_vy[i] - dy;
            a_in2  = st_a[i] + ATAN_TURNS[i];
         end else begin
            vx_in2 = st_vx[i] - dx;
            vy_in2 = st_vy[i] + dy;
            a_in2  = st_a[i] - ATAN_TURNS[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff <= '0;
         end else begin
            ctrl_ff <= st_ctrl[i];
         end
      end

      always_ff @(posedge clock) begin
         skip_ff <= st_skip[i];
         vx_ff   <= vx_in2;
         vy_ff   <= vy_in2;
         a_ff    <= a_in2;
         rx_ff   <= st_rx[i];
         ry_ff   <= st_ry[i];
      end

      assign st_ctrl[i+1] = ctrl_ff;
      assign st_skip[i+1] = skip_ff;
      assign st_vx[i+1]   = vx_ff;
      assign st_vy[i+1]   = vy_ff;
      assign st_a[i+1]    = a_ff;
      assign st_rx[i+1]   = rx_ff;
      assign st_ry[i+1]   = ry_ff;
   end

   assign out_ctrl = st_ctrl[N];
   assign angle    = st_a[N];
   assign r_x      = st_rx[N];
   assign r_y      = st_ry[N];

endmodule

@@ src/kim_sector.sv @@
// Sector stages: sector width from the count, sector number by a bit-per-stage
// divider, then the back-rotation angle. Depends on kim_pkg.
module kim_sector import kim_pkg::*; #(
   parameter int MAX_SECTORS = 100
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [6:0]           sector_count,
   input  ctrl_type             in_ctrl,
   input  logic [31:0]          angle,
   input  logic signed [DW-1:0] in_x,
   input  logic signed [DW-1:0] in_y,
   output ctrl_type             out_ctrl,
   output logic [31:0]          rot,
   output logic                 mirrored,
   output logic signed [DW-1:0] out_x,
   output logic signed [DW-1:0] out_y
);

   localparam int CW = $clog2(MAX_SECTORS + 1);
   localparam int SW = $clog2(2 * MAX_SECTORS + 1);
   localparam int LW = 32 + SW;
   localparam int RB = 4;
   localparam int RS = 32 / RB;

   // Sector width: free-running restoring division of 2^31 by the count.
   logic [8:0]    c_wide;
   logic [CW-1:0] c_eff;
   logic [CW-1:0] rc   [0:RS];
   logic [CW-1:0] rrem [0:RS];
   logic [31:0]   rq   [0:RS];
   logic [CW-1:0] rc0_ff;
   logic [31:0]   width;

   assign c_wide = {2'b00, sector_count};
   assign c_eff  = (c_wide == 9'd0) ? CW'(1) :
                   (c_wide > 9'(MAX_SECTORS)) ? CW'(MAX_SECTORS) : CW'(c_wide);

   always_ff @(posedge clock) begin
      rc0_ff <= c_eff;
   end

   assign rc[0]   = rc0_ff;
   assign rrem[0] = '0;
   assign rq[0]   = '0;

   for (genvar g = 0; g < RS; g++) begin : g_recip
      logic [CW:0]   rem_v;
      logic [31:0]   q_v;
      logic [CW-1:0] c_ff, rem_ff;
      logic [31:0]   q_ff;

      always_comb begin
         rem_v = {1'b0, rrem[g]};
         q_v   = rq[g];
         for (int b = 0; b < RB; b++) begin
            rem_v = {rem_v[CW-1:0], (g == 0 && b == 0) ? 1'b1 : 1'b0};
            if (rem_v >= {1'b0, rc[g]}) begin
               rem_v = rem_v - {1'b0, rc[g]};
               q_v[31 - RB * g - b] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         c_ff   <= rc[g];
         rem_ff <= rem_v[CW-1:0];
         q_ff   <= q_v;
      end

      assign rc[g+1]   = c_ff;
      assign rrem[g+1] = rem_ff;
      assign rq[g+1]   = q_ff;
   end

   assign width = rq[RS];

   // Sector number: one quotient bit per stage.
   ctrl_type             st_ctrl [0:SW];
   logic [31:0]          st_rem  [0:SW];
   logic [SW-1:0]        st_s    [0:SW];
   logic signed [DW-1:0] st_x    [0:SW];
   logic signed [DW-1:0] st_y    [0:SW];

   assign st_ctrl[0] = in_ctrl;
   assign st_rem[0]  = angle;
   assign st_s[0]    = '0;
   assign st_x[0]    = in_x;
   assign st_y[0]    = in_y;

   for (genvar k = 0; k < SW; k++) begin : g_div
      localparam int B = SW - 1 - k;
      logic [LW-1:0]        wsh, remx;
      logic                 take;
      ctrl_type             ctrl_ff;
      logic [31:0]          rem_ff;
      logic [SW-1:0]        s_ff, s_v;
      logic signed [DW-1:0] x_ff, y_ff;

      assign wsh  = LW'(width) << B;
      assign remx = LW'(st_rem[k]);
      assign take = (remx >= wsh);

      always_comb begin
         s_v    = st_s[k];
         s_v[B] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff <= '0;
         end else begin
            ctrl_ff <= st_ctrl[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff <= take ? 32'(remx - wsh) : st_rem[k];
         s_ff   <= s_v;
         x_ff   <= st_x[k];
         y_ff   <= st_y[k];
      end

      assign st_ctrl[k+1] = ctrl_ff;
      assign st_rem[k+1]  = rem_ff;
      assign st_s[k+1]    = s_ff;
      assign st_x[k+1]    = x_ff;
      assign st_y[k+1]    = y_ff;
   end

   // Product of sector number and width, then the rotation angle.
   logic [SW+31:0]       prod;
   ctrl_type             m_ctrl_ff, o_ctrl_ff;
   logic [31:0]          m_p_ff, o_rot_ff;
   logic                 m_odd_ff, o_odd_ff;
   logic signed [DW-1:0] m_x_ff, m_y_ff, o_x_ff, o_y_ff;

   assign prod = (SW + 32)'(st_s[SW]) * (SW + 32)'(width);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ctrl_ff <= '0;
         o_ctrl_ff <= '0;
      end else begin
         m_ctrl_ff <= st_ctrl[SW];
         o_ctrl_ff <= m_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      m_p_ff   <= prod[31:0];
      m_odd_ff <= st_s[SW][0];
      m_x_ff   <= st_x[SW];
      m_y_ff   <= st_y[SW];
      o_rot_ff <= m_odd_ff ? (m_p_ff + width) : (32'd0 - m_p_ff);
      o_odd_ff <= m_odd_ff;
      o_x_ff   <= m_x_ff;
      o_y_ff   <= m_odd_ff ? -m_y_ff : m_y_ff;
   end

   assign out_ctrl = o_ctrl_ff;
   assign rot      = o_rot_ff;
   assign mirrored = o_odd_ff;
   assign out_x    = o_x_ff;
   assign out_y    = o_y_ff;

endmodule

@@ src/kim_rotate.sv @@
// Rotation CORDIC pipeline: quarter-turn pre-rotation, then one step per stage.
// Depends on kim_pkg.
module kim_rotate import kim_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             in_ctrl,
   input  logic [31:0]          rot,
   input  logic                 in_mirrored,
   input  logic signed [DW-1:0] in_x,
   input  logic signed [DW-1:0] in_y,
   output ctrl_type             out_ctrl,
   output logic                 out_mirrored,
   output logic signed [DW-1:0] out_x,
   output logic signed [DW-1:0] out_y
);

   localparam int N = CORDIC_STEPS;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   logic [31:0]          rot_b;
   logic [1:0]           quad;
   logic signed [DW-1:0] px, py;
   ctrl_type             ctrl0_ff;
   logic                 mir0_ff;
   logic signed [DW-1:0] x0_ff, y0_ff;
   logic signed [ZW-1:0] z0_ff;

   assign rot_b = rot + EIGHTH_TURN;
   assign quad  = rot_b[31:30];

   always_comb begin
      case (quad)
         QUAD_1: begin
            px = -in_y;
            py = in_x;
         end
         QUAD_2: begin
            px = -in_x;
            py = -in_y;
         end
         QUAD_3: begin
            px = in_y;
            py = -in_x;
         end
         default: begin
            px = in_x;
            py = in_y;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
      end else begin
         ctrl0_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      mir0_ff <= in_mirrored;
      x0_ff   <= px;
      y0_ff   <= py;
      z0_ff   <= ZW'($signed(rot - {quad, 30'd0}));
   end

   ctrl_type             st_ctrl [0:N];
   logic                 st_mir  [0:N];
   logic signed [DW-1:0] st_x    [0:N];
   logic signed [DW-1:0] st_y    [0:N];
   logic signed [ZW-1:0] st_z    [0:N];

   assign st_ctrl[0] = ctrl0_ff;
   assign st_mir[0]  = mir0_ff;
   assign st_x[0]    = x0_ff;
   assign st_y[0]    = y0_ff;
   assign st_z[0]    = z0_ff;

   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [DW-1:0] dx, dy, x_ff, y_ff;
      logic signed [ZW-1:0] at, z_ff;
      ctrl_type             ctrl_ff;
      logic                 mir_ff;

      assign dx = st_y[i] >>> i;
      assign dy = st_x[i] >>> i;
      assign at = ZW'(ATAN_TURNS[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff <= '0;
         end else begin
            ctrl_ff <= st_ctrl[i];
         end
      end

      always_ff @(posedge clock) begin
         mir_ff <= st_mir[i];
         if (st_z[i] >= 0) begin
            x_ff <= st_x[i] - dx;
            y_ff <= st_y[i] + dy;
            z_ff <= st_z[i] - at;
         end else begin
            x_ff <= st_x[i] + dx;
            y_ff <= st_y[i] - dy;
            z_ff <= st_z[i] + at;
         end
      end

      assign st_ctrl[i+1] = ctrl_ff;
      assign st_mir[i+1]  = mir_ff;
      assign st_x[i+1]    = x_ff;
      assign st_y[i+1]    = y_ff;
      assign st_z[i+1]    = z_ff;
   end

   assign out_ctrl     = st_ctrl[N];
   assign out_mirrored = st_mir[N];
   assign out_x        = st_x[N];
   assign out_y        = st_y[N];

endmodule

@@ src/kim_scale.sv @@
// Gain removal, guard-bit rounding, output offset and saturation, in four stages.
// Depends on kim_pkg.
module kim_scale import kim_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             in_ctrl,
   input  logic                 in_mirrored,
   input  logic signed [DW-1:0] in_x,
   input  logic signed [DW-1:0] in_y,
   input  logic [63:0]          output_offset,
   output ctrl_type             out_ctrl,
   output logic signed [31:0]   source_x,
   output logic signed [31:0]   source_y,
   output logic                 mirrored
);

   localparam int HW = DW - 32;
   localparam int RW = DW + 1;
   localparam int TW = RW + 1 - GUARD;

   // Stage 1: sign and magnitude.
   ctrl_type    c1_ff, c2_ff, c3_ff, c4_ff;
   logic        m1_ff, m2_ff, m3_ff, m4_ff;
   logic        nx1_ff, ny1_ff, nx2_ff, ny2_ff;
   logic [DW-1:0] ux1_ff, uy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
      end else begin
         c1_ff <= in_ctrl;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_ff  <= in_mirrored;
      nx1_ff <= in_x[DW-1];
      ny1_ff <= in_y[DW-1];
      ux1_ff <= in_x[DW-1] ? DW'(-in_x) : DW'(in_x);
      uy1_ff <= in_y[DW-1] ? DW'(-in_y) : DW'(in_y);
   end

   // Stage 2: split products with the inverse gain.
   logic [HW+31:0] hx2_ff, hy2_ff;
   logic [63:0]    lx2_ff, ly2_ff;

   always_ff @(posedge clock) begin
      m2_ff  <= m1_ff;
      nx2_ff <= nx1_ff;
      ny2_ff <= ny1_ff;
      hx2_ff <= (HW + 32)'(ux1_ff[DW-1:32]) * (HW + 32)'(INV_GAIN);
      hy2_ff <= (HW + 32)'(uy1_ff[DW-1:32]) * (HW + 32)'(INV_GAIN);
      lx2_ff <= 64'(ux1_ff[31:0]) * 64'(INV_GAIN);
      ly2_ff <= 64'(uy1_ff[31:0]) * 64'(INV_GAIN);
   end

   // Stage 3: combine, round half away from zero, restore sign.
   logic [64:0]          lx_r, ly_r;
   logic [RW-1:0]        rx, ry;
   logic signed [RW:0]   vx3_ff, vy3_ff;

   assign lx_r = 65'(lx2_ff) + 65'h0_8000_0000;
   assign ly_r = 65'(ly2_ff) + 65'h0_8000_0000;
   assign rx   = RW'(hx2_ff) + RW'(lx_r[64:32]);
   assign ry   = RW'(hy2_ff) + RW'(ly_r[64:32]);

   always_ff @(posedge clock) begin
      m3_ff  <= m2_ff;
      vx3_ff <= nx2_ff ? -$signed({1'b0, rx}) : $signed({1'b0, rx});
      vy3_ff <= ny2_ff ? -$signed({1'b0, ry}) : $signed({1'b0, ry});
   end

   // Stage 4: drop guard bits, add offset, saturate.
   logic signed [RW:0]   hx, hy;
   logic signed [TW:0]   sx, sy;
   logic signed [31:0]   ox, oy, fx, fy, sx_sat, sy_sat;
   logic signed [31:0]   x4_ff, y4_ff;

   assign ox = $signed(output_offset[31:0]);
   assign oy = $signed(output_offset[63:32]);
   assign hx = vx3_ff + (RW + 1)'(1 << (GUARD - 1));
   assign hy = vy3_ff + (RW + 1)'(1 << (GUARD - 1));
   assign sx = (TW + 1)'($signed(hx[RW:GUARD])) + (TW + 1)'(ox);
   assign sy = (TW + 1)'($signed(hy[RW:GUARD])) + (TW + 1)'(oy);

   assign sx_sat = (sx > (TW + 1)'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                   (sx < -(TW + 1)'(64'sh8000_0000)) ? 32'sh8000_0000 : 32'(sx);
   assign sy_sat = (sy > (TW + 1)'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                   (sy < -(TW + 1)'(64'sh8000_0000)) ? 32'sh8000_0000 : 32'(sy);
   assign fx = c3_ff.zero ? ox : sx_sat;
   assign fy = c3_ff.zero ? oy : sy_sat;

   always_ff @(posedge clock) begin
      m4_ff <= m3_ff && !c3_ff.zero;
      x4_ff <= fx;
      y4_ff <= fy;
   end

   assign out_ctrl = c4_ff;
   assign source_x = x4_ff;
   assign source_y = y4_ff;
   assign mirrored = m4_ff;

endmodule

@@ src/kaleidoscope_inverse_map_core.sv @@
// Kaleidoscope inverse map top level: configuration registers and the pipeline.
// Depends on kim_pkg and kim_affine, kim_vector, kim_sector, kim_rotate, kim_scale.
// One request per cycle outside reset; CORDIC chains and divider set the depth.
// Synchronous reset clears the pipeline valid bits and loads register defaults.
// Busy is high only during reset; each result is strobed on rsp_valid for one cycle.
// The receiver cannot stall the pipeline.
`include "kaleidoscope_inverse_map_core_defines.svh"

module kaleidoscope_inverse_map_core import kim_pkg::*; #(
   parameter int CORDIC_STEPS = 24,
   parameter int MAX_SECTORS  = 100
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_pixel_x,
   input  logic signed [23:0] req_pixel_y,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_source_x,
   output logic signed [31:0] rsp_source_y,
   output logic               rsp_mirrored,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   localparam int SW = $clog2(2 * MAX_SECTORS + 1);
   localparam int LATENCY = 10 + 2 * CORDIC_STEPS + SW;

   logic [31:0] coef_xx_ff, coef_xy_ff, coef_yx_ff, coef_yy_ff;
   logic [63:0] aoff_ff, ooff_ff;
   logic [6:0]  count_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff <= 32'h1000_0000;
         coef_xy_ff <= '0;
         coef_yx_ff <= '0;
         coef_yy_ff <= 32'h1000_0000;
         aoff_ff    <= '0;
         ooff_ff    <= '0;
         count_ff   <= 7'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_COEF_XX: coef_xx_ff <= csr_data[31:0];
            REG_COEF_XY: coef_xy_ff <= csr_data[31:0];
            REG_COEF_YX: coef_yx_ff <= csr_data[31:0];
            REG_COEF_YY: coef_yy_ff <= csr_data[31:0];
            REG_AFF_OFF: aoff_ff    <= csr_data;
            REG_OUT_OFF: ooff_ff    <= csr_data;
            REG_SECTORS: count_ff   <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   logic                 a_valid;
   logic signed [QW-1:0] q_x, q_y;
   ctrl_type             v_ctrl, s_ctrl, r_ctrl, o_ctrl;
   logic [31:0]          v_angle, s_rot;
   logic signed [DW-1:0] v_x, v_y, s_x, s_y, r_x, r_y;
   logic                 s_mir, r_mir;
   logic                 zero_vec_ok;

   kim_affine u_affine (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start && !busy),
      .pixel_x       (req_pixel_x),
      .pixel_y       (req_pixel_y),
      .coef_xx       ($signed(coef_xx_ff)),
      .coef_xy       ($signed(coef_xy_ff)),
      .coef_yx       ($signed(coef_yx_ff)),
      .coef_yy       ($signed(coef_yy_ff)),
      .affine_offset (aoff_ff),
      .out_valid     (a_valid),
      .q_x           (q_x),
      .q_y           (q_y)
   );

   kim_vector #(.CORDIC_STEPS(CORDIC_STEPS)) u_vector (
      .clock    (clock),
      .reset    (reset),
      .in_valid (a_valid),
      .q_x      (q_x),
      .q_y      (q_y),
      .out_ctrl (v_ctrl),
      .angle    (v_angle),
      .r_x      (v_x),
      .r_y      (v_y)
   );

   kim_sector #(.MAX_SECTORS(MAX_SECTORS)) u_sector (
      .clock        (clock),
      .reset        (reset),
      .sector_count (count_ff),
      .in_ctrl      (v_ctrl),
      .angle        (v_angle),
      .in_x         (v_x),
      .in_y         (v_y),
      .out_ctrl     (s_ctrl),
      .rot          (s_rot),
      .mirrored     (s_mir),
      .out_x        (s_x),
      .out_y        (s_y)
   );

   kim_rotate #(.CORDIC_STEPS(CORDIC_STEPS)) u_rotate (
      .clock        (clock),
      .reset        (reset),
      .in_ctrl      (s_ctrl),
      .rot          (s_rot),
      .in_mirrored  (s_mir),
      .in_x         (s_x),
      .in_y         (s_y),
      .out_ctrl     (r_ctrl),
      .out_mirrored (r_mir),
      .out_x        (r_x),
      .out_y        (r_y)
   );

   kim_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .in_ctrl       (r_ctrl),
      .in_mirrored   (r_mir),
      .in_x          (r_x),
      .in_y          (r_y),
      .output_offset (ooff_ff),
      .out_ctrl      (o_ctrl),
      .source_x      (rsp_source_x),
      .source_y      (rsp_source_y),
      .mirrored      (rsp_mirrored)
   );

   assign rsp_valid = o_ctrl.valid;
   assign zero_vec_ok = !rsp_mirrored && (rsp_source_x == $signed(ooff_ff[31:0]));

   `KIM_ASSERT_NOW(a_latency, rsp_valid, $past(start && !busy, LATENCY), "result without request")
   `KIM_ASSERT_NOW(a_zero_vec, o_ctrl.valid && o_ctrl.zero, zero_vec_ok, "zero vector mismatch")
   `KIM_ASSERT_NEXT(a_busy_rel, !reset, !busy || reset, "busy outside reset")

endmodule

@@ test/kaleidoscope_inverse_map_core_tb.sv @@
// Self-checking testbench for kaleidoscope_inverse_map_core: a directed table of pixels,
// then random pixels over several register settings, each checked against a local mapper.
// Depends on kim_pkg and the kaleidoscope_inverse_map_core RTL.
module kaleidoscope_inverse_map_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kim_pkg::*;

   localparam int STEPS      = 24;
   localparam int SECT_MAX   = 100;
   localparam int DRAIN      = 100;
   localparam int WATCHDOG   = 5000;
   localparam int PHASES     = 12;
   localparam int PHASE_REQS = 170;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [31:0] sx;
      logic [31:0] sy;
      logic        mir;
   } source_type;

   typedef struct packed {
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic               typed;
      source_type         want;
   } pixel_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [23:0] req_pixel_x = '0;
   logic signed [23:0] req_pixel_y = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_source_x, rsp_source_y;
   logic rsp_mirrored;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [31:0] m_xx = 32'h1000_0000, m_xy = '0, m_yx = '0, m_yy = 32'h1000_0000;
   logic [63:0] m_aoff = '0, m_ooff = '0;
   logic [6:0]  m_sect = 7'd3;

   source_type source_q[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit allow_idle = 1'b1;

   always #5 clock = ~clock;

   kaleidoscope_inverse_map_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_source_x(rsp_source_x), .rsp_source_y(rsp_source_y),
      .rsp_mirrored(rsp_mirrored),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   function automatic logic [31:0] polar_angle(longint x, longint y);
      logic [31:0] a;
      longint dx, dy;
      a = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         a = HALF_TURN;
      end
      if (y == 0) return a;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; a += ATAN_TURNS[i];
         end else begin
            x -= dx; y += dy; a -= ATAN_TURNS[i];
         end
      end
      return a;
   endfunction

   function automatic void turn_vector(inout longint x, inout longint y, input logic [31:0] rot);
      logic [31:0] k, zr;
      longint z, t, dx, dy;
      k = (rot + EIGHTH_TURN) >> 30;
      zr = rot - (k << 30);
      z = longint'($signed(zr));
      if (k == 1) begin
         t = x; x = -y; y = t;
      end else if (k == 2) begin
         x = -x; y = -y;
      end else if (k == 3) begin
         t = x; x = y; y = -t;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'({32'd0, ATAN_TURNS[i]});
         end else begin
            x += dx; y -= dy; z += longint'({32'd0, ATAN_TURNS[i]});
         end
      end
   endfunction

   function automatic longint remove_gain(longint v);
      logic neg;
      logic [63:0] u, hi, lo, r;
      neg = v < 0;
      u = neg ? -v : v;
      hi = u >> 32;
      lo = u & 64'hFFFF_FFFF;
      r = hi * {32'd0, INV_GAIN} + ((lo * {32'd0, INV_GAIN} + 64'h8000_0000) >> 32);
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic source_type kaleido_map(logic signed [23:0] px, logic signed [23:0] py);
      source_type r;
      longint qx, qy, rx, ry, ox, oy;
      logic [31:0] a, w, s, rot;
      int c;
      ox = longint'($signed(m_ooff[31:0]));
      oy = longint'($signed(m_ooff[63:32]));
      qx = ((longint'($signed(m_xx)) * longint'(px) + longint'($signed(m_xy)) * longint'(py)
            + (64'sd1 <<< 27)) >>> 28) + longint'($signed(m_aoff[31:0]));
      qy = ((longint'($signed(m_yx)) * longint'(px) + longint'($signed(m_yy)) * longint'(py)
            + (64'sd1 <<< 27)) >>> 28) + longint'($signed(m_aoff[63:32]));
      if (qx == 0 && qy == 0) begin
         r.sx = clip32(ox);
         r.sy = clip32(oy);
         r.mir = 1'b0;
         return r;
      end
      rx = qx <<< GUARD;
      ry = qy <<< GUARD;
      a = polar_angle(rx, ry);
      c = int'(m_sect);
      if (c < 1) c = 1;
      if (c > SECT_MAX) c = SECT_MAX;
      w = 32'h8000_0000 / c;
      s = a / w;
      if (s[0]) begin
         rot = (s + 1) * w;
         ry = -ry;
      end else begin
         rot = 32'd0 - s * w;
      end
      turn_vector(rx, ry, rot);
      rx = (remove_gain(rx) + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      ry = (remove_gain(ry) + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      r.sx = clip32(rx + ox);
      r.sy = clip32(ry + oy);
      r.mir = s[0];
      return r;
   endfunction

   always @(posedge clock) begin
      source_type want;
      if (!reset && rsp_valid) begin
         if (source_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result x=%h y=%h m=%b", rsp_source_x, rsp_source_y,
                        rsp_mirrored);
         end else begin
            want = source_q.pop_front();
            if (rsp_source_x !== want.sx || rsp_source_y !== want.sy ||
                rsp_mirrored !== want.mir) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected x=%h y=%h m=%b, got x=%h y=%h m=%b",
                           want.sx, want.sy, want.mir, rsp_source_x, rsp_source_y,
                           rsp_mirrored);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_pixel(logic signed [23:0] px, logic signed [23:0] py, logic typed,
                             source_type want);
      logic held;
      start <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      do begin
         @(negedge clock);
         held = busy;
         @(posedge clock);
      end while (held);
      source_q.push_back(typed ? want : kaleido_map(px, py));
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [63:0] value);
      logic rdy;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(negedge clock);
         rdy = csr_ready;
         @(posedge clock);
      end while (!rdy);
      case (idx)
         REG_COEF_XX: m_xx = value[31:0];
         REG_COEF_XY: m_xy = value[31:0];
         REG_COEF_YX: m_yx = value[31:0];
         REG_COEF_YY: m_yy = value[31:0];
         REG_AFF_OFF: m_aoff = value;
         REG_OUT_OFF: m_ooff = value;
         REG_SECTORS: m_sect = value[6:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      start <= 1'b0;
      while (source_q.size() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coef();
      logic [31:0] c;
      c = $urandom;
      if ($urandom_range(0, 3) != 0) c = {{3{c[28]}}, c[28:0]};
      return c;
   endfunction

   function automatic logic [63:0] rand_offset();
      logic [63:0] v;
      v = {$urandom, $urandom};
      if ($urandom_range(0, 2) != 0) v = {{12{v[51]}}, v[51:32], {12{v[19]}}, v[19:0]};
      if ($urandom_range(0, 4) == 0) v = '0;
      return v;
   endfunction

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(0, 4))
         0, 1: return 24'($urandom);
         2: return 24'($signed($urandom_range(0, 8191)) - 4096);
         3: return 24'($signed($urandom_range(0, 511)) - 256);
         default: return '0;
      endcase
   endfunction

   task automatic configure(int phase);
      logic [31:0] cxx, cxy, cyx, cyy;
      logic [63:0] aoff, ooff;
      logic [6:0] sect;
      cxx = rand_coef(); cxy = rand_coef(); cyx = rand_coef(); cyy = rand_coef();
      aoff = rand_offset(); ooff = rand_offset();
      sect = 7'($urandom_range(1, 12));
      case (phase)
         1: begin
            cxx = 32'h1000_0000; cxy = '0; cyx = '0; cyy = 32'h1000_0000;
            aoff = '0; ooff = '0; sect = 7'd1;
         end
         2: sect = 7'd100;
         3: sect = 7'd0;
         4: begin
            cxx = 32'h7FFF_FFFF; cxy = 32'h7FFF_FFFF; cyx = 32'h8000_0000;
            cyy = 32'h7FFF_FFFF; sect = 7'd127;
         end
         5: begin
            cxx = 32'h8000_0000; cxy = 32'h8000_0000; cyx = 32'h8000_0000;
            cyy = 32'h8000_0000;
            aoff = 64'h8000_0000_7FFF_FFFF; ooff = 64'h7FFF_FFFF_8000_0000;
         end
         6: begin
            cxx = '0; cxy = '0; cyx = '0; cyy = '0; aoff = '0;
            ooff = 64'hFFFF_FFFF_FFFF_FFFF;
         end
         7: sect = 7'($urandom_range(13, 127));
         default: ;
      endcase
      write_reg(REG_COEF_XX, {$urandom, cxx});
      write_reg(REG_COEF_XY, {$urandom, cxy});
      write_reg(REG_COEF_YX, {$urandom, cyx});
      write_reg(REG_COEF_YY, {$urandom, cyy});
      write_reg(REG_AFF_OFF, aoff);
      write_reg(REG_OUT_OFF, ooff);
      write_reg(REG_SECTORS, {$urandom, 25'($urandom), sect});
      write_reg(REG_UNUSED, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   pixel_row_type dir_rows[20];

   initial begin
      source_type none;
      none = '0;
      dir_rows = '{
         '{24'sd0, 24'sd0, 1'b1, '{32'd0, 32'd0, 1'b0}},
         '{24'sd256, 24'sd0, 1'b0, none}, '{-24'sd256, 24'sd0, 1'b0, none},
         '{24'sd0, 24'sd256, 1'b0, none}, '{24'sd0, -24'sd256, 1'b0, none},
         '{24'h7FFFFF, 24'sd0, 1'b0, none}, '{24'h800000, 24'sd0, 1'b0, none},
         '{24'h7FFFFF, 24'h7FFFFF, 1'b0, none}, '{24'h800000, 24'h800000, 1'b0, none},
         '{24'h7FFFFF, 24'h800000, 1'b0, none}, '{24'h800000, 24'h7FFFFF, 1'b0, none},
         '{24'sd1, 24'sd0, 1'b0, none}, '{24'sd0, 24'sd1, 1'b0, none},
         '{-24'sd1, 24'sd0, 1'b0, none}, '{24'sd1, 24'sd1, 1'b0, none},
         '{-24'sd1, -24'sd1, 1'b0, none}, '{24'sd256, 24'sd443, 1'b0, none},
         '{24'sd443, 24'sd256, 1'b0, none}, '{-24'sd443, -24'sd256, 1'b0, none},
         '{24'sd300, -24'sd100, 1'b0, none}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].typed, dir_rows[i].want);
      drain();
      for (int p = 1; p <= PHASES; p++) begin
         configure(p);
         allow_idle = (p < PHASES);
         for (int n = 0; n < PHASE_REQS; n++)
            send_pixel(rand_coord(), rand_coord(), 1'b0, none);
         drain();
      end
      if (mismatches == 0 && source_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
